FILE: design/fwht_pkg.sv
`timescale 1ns / 1ps

package fwht_pkg;

	localparam int SAMPLE_W       = 16;
	localparam int COEF_W         = 23;
	localparam int IDX_W          = 6;
	localparam int LOGSIZE_W      = 3;
	localparam int LOG_POINTS_DEF = 6;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic [LOGSIZE_W-1:0]       logsize_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_XFORM,
		ST_DRAIN
	} state_t;

	// per-cycle commands from the sequencer to the cell row
	typedef struct packed {
		logic shift;        // every cell takes its input
		logic tail_wr;      // tail cell takes the tail value
		logic tail_from_in; // tail value is the incoming sample
		logic bfly;         // butterfly: tail cell gets sum, the cell the partner moves into gets difference
		logic emit;         // head goes to the output register
		logic emit_last;    // that coefficient closes the frame
	} ctrl_t;

endpackage

FILE: design/fwht_if.sv
`timescale 1ns / 1ps

interface fwht_sample_if;
	logic              valid;
	logic              ready;
	fwht_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface fwht_coef_if;
	logic                          valid;
	logic                          ready;
	fwht_pkg::coef_t               coefficient;
	logic [fwht_pkg::IDX_W-1:0]    coeff_index;
	logic                          last;

	modport source (output valid, output coefficient, output coeff_index, output last,
		input ready);
	modport sink   (input valid, input coefficient, input coeff_index, input last,
		output ready);
endinterface

interface fwht_cfg_if;
	logic               valid;
	logic               ready;
	fwht_pkg::logsize_t log_size;

	modport source (output valid, output log_size, input ready);
	modport sink   (input valid, input log_size, output ready);
endinterface

FILE: design/fwht_cell.sv
`timescale 1ns / 1ps

module fwht_cell (
	input  logic            clk,
	input  logic            en,
	input  logic            sel,
	input  fwht_pkg::coef_t alt,
	input  fwht_pkg::coef_t nbr,
	output fwht_pkg::coef_t q
);
	import fwht_pkg::*;

	coef_t val_q;

	// no reset: contents are always written before they are read
	always_ff @(posedge clk) begin
		if (en) begin
			val_q <= sel ? alt : nbr;
		end
	end

	assign q = val_q;

endmodule

FILE: design/fwht_ctrl.sv
`timescale 1ns / 1ps

module fwht_ctrl #(
	parameter int LOG_POINTS = fwht_pkg::LOG_POINTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  fwht_pkg::logsize_t         cfg_data,
	input  logic                       in_valid,
	input  logic                       out_free,
	output logic                       in_ready,
	output fwht_pkg::ctrl_t            ctl,
	output logic [LOG_POINTS-1:0]      tail_idx,
	output logic [LOG_POINTS-1:0]      wr_idx,
	output logic [LOG_POINTS-1:0]      tap_idx,
	output logic [LOG_POINTS-1:0]      emit_idx
);
	import fwht_pkg::*;

	localparam int KMAX = (LOG_POINTS > 7) ? 7 : LOG_POINTS;

	state_t                state_q, state_d;
	logsize_t              log_size_q;
	logsize_t              k;
	logsize_t              pass_q;
	logic [LOG_POINTS-1:0] cnt_q;
	logic [LOG_POINTS-1:0] mask;
	logic [LOG_POINTS-1:0] stride;
	logic                  last_cnt;
	logic                  last_pass;
	logic                  bit_clear;

	// effective log size, clamped to 1..KMAX
	always_comb begin
		if (log_size_q == '0) begin
			k = LOGSIZE_W'(1);
		end else if (log_size_q > LOGSIZE_W'(KMAX)) begin
			k = LOGSIZE_W'(KMAX);
		end else begin
			k = log_size_q;
		end
	end

	// frame length minus one
	always_comb begin
		for (int b = 0; b < LOG_POINTS; b++) begin
			mask[b] = (b < int'(k));
		end
	end

	assign stride    = LOG_POINTS'(1) << pass_q;
	assign last_cnt  = (cnt_q == mask);
	assign last_pass = (pass_q == k - LOGSIZE_W'(1));
	assign bit_clear = ((cnt_q & stride) == '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_valid && last_cnt) begin
					state_d = ST_XFORM;
				end
			end
			ST_XFORM: begin
				if (last_cnt && last_pass) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_free && last_cnt) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				in_ready         = 1'b1;
				ctl.shift        = in_valid;
				ctl.tail_wr      = in_valid;
				ctl.tail_from_in = 1'b1;
			end
			ST_XFORM: begin
				ctl.shift   = 1'b1;
				ctl.tail_wr = 1'b1;
				ctl.bfly    = bit_clear;
			end
			ST_DRAIN: begin
				ctl.shift     = out_free;
				ctl.tail_wr   = out_free;
				ctl.emit      = out_free;
				ctl.emit_last = last_cnt;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_size_q <= LOGSIZE_W'(LOG_POINTS_DEF);
			cnt_q      <= '0;
			pass_q     <= '0;
		end else if (cfg_we) begin
			// a write drops any partial frame
			log_size_q <= cfg_data;
			cnt_q      <= '0;
		end else if (ctl.shift) begin
			cnt_q <= last_cnt ? '0 : cnt_q + LOG_POINTS'(1);
			if (state_q == ST_XFORM && last_cnt) begin
				pass_q <= last_pass ? '0 : pass_q + LOGSIZE_W'(1);
			end
		end
	end

	assign tail_idx = mask;
	assign tap_idx  = stride;
	assign wr_idx   = stride - LOG_POINTS'(1);
	assign emit_idx = cnt_q;

	a_cnt_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q & ~mask) == '0)
		else $error("position count beyond frame");

	a_pass_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		pass_q < k)
		else $error("butterfly pass beyond log size");

	a_last_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit && ctl.emit_last |=> state_q == ST_LOAD)
		else $error("not back to loading after last coefficient");

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.bfly |-> wr_idx != tail_idx)
		else $error("butterfly write hits tail cell");

endmodule

FILE: design/fast_walsh_hadamard_transform_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                               Item accepted
// samples   in   sample[15:0] signed                   samples.valid && samples.ready
// coeffs    out  coefficient[22:0] signed, coeff_index[5:0], last
//                                                      coeffs.valid && coeffs.ready
// cfg       in   log_size[2:0]                         cfg.valid && cfg.ready (ready stays high)
//
// A frame of N = 2^k samples (k = log_size clamped to 1..LOG_POINTS) loads one per cycle.
// The transform then runs k passes, each one full turn of the cell row.
// Draining then emits the N coefficients in index order through the output register.
// Samples are refused during transform and drain; coeffs stalls freeze the row in drain.
// Reset clears the sequencer, sets log_size to 6 and the output to empty.
module fast_walsh_hadamard_transform_core #(
	parameter int LOG_POINTS = fwht_pkg::LOG_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	fwht_sample_if.sink samples,
	fwht_coef_if.source coeffs,
	fwht_cfg_if.sink    cfg
);
	import fwht_pkg::*;

	localparam int P = 1 << LOG_POINTS;

	// The cells form a ring, cell 0 is the head. On each shift every cell takes the
	// value of its right neighbor; the tail cell (N-1) takes the new sample while
	// loading, or the recirculated head value during the transform and drain.
	//
	// Pass with stride h: when the head holds element j with bit h of j clear,
	// its partner j+h sits in cell h. Head+partner goes to the tail, and
	// head-partner replaces the partner as it moves into cell h-1. When the
	// partner reaches the head later it already holds its difference and just
	// goes round.

	ctrl_t                 ctl;
	logic                  out_free;
	logic [LOG_POINTS-1:0] tail_idx, wr_idx, tap_idx, emit_idx;

	coef_t cell_q   [P];
	logic  cell_sel [P];
	coef_t cell_alt [P];
	coef_t cell_nbr [P];

	// partner candidates: only cells 1, 2, 4, ... can hold the partner
	coef_t tap_cand [LOG_POINTS];

	coef_t head, tap, sum, diff, tail_data;

	logic                 out_valid_q;
	coef_t                coef_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 last_q;

	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || coeffs.ready;

	fwht_ctrl #(
		.LOG_POINTS(LOG_POINTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg.valid),
		.cfg_data(cfg.log_size),
		.in_valid(samples.valid),
		.out_free(out_free),
		.in_ready(samples.ready),
		.ctl     (ctl),
		.tail_idx(tail_idx),
		.wr_idx  (wr_idx),
		.tap_idx (tap_idx),
		.emit_idx(emit_idx)
	);

	for (genvar b = 0; b < LOG_POINTS; b++) begin : g_tap
		assign tap_cand[b] = cell_q[2**b];
	end

	// tap_idx is one-hot: select among the power-of-two cells
	always_comb begin
		tap = '0;
		for (int b = 0; b < LOG_POINTS; b++) begin
			if (tap_idx[b]) begin
				tap = tap_cand[b];
			end
		end
	end

	// butterfly at the head of the row
	assign head = cell_q[0];
	assign sum  = head + tap;
	assign diff = head - tap;

	always_comb begin
		if (ctl.tail_from_in) begin
			tail_data = COEF_W'(samples.sample);
		end else if (ctl.bfly) begin
			tail_data = sum;
		end else begin
			tail_data = head;
		end
	end

	for (genvar i = 0; i < P; i++) begin : g_cell
		logic is_tail, is_wr;

		assign is_tail     = (tail_idx == LOG_POINTS'(i));
		assign is_wr       = (wr_idx == LOG_POINTS'(i));
		assign cell_sel[i] = (ctl.tail_wr && is_tail) || (ctl.bfly && is_wr);
		assign cell_alt[i] = is_tail ? tail_data : diff;

		if (i == P - 1) begin : g_end
			assign cell_nbr[i] = tail_data;
		end else begin : g_mid
			assign cell_nbr[i] = cell_q[i+1];
		end

		fwht_cell u_cell (
			.clk(clk),
			.en (ctl.shift),
			.sel(cell_sel[i]),
			.alt(cell_alt[i]),
			.nbr(cell_nbr[i]),
			.q  (cell_q[i])
		);
	end

	// output register: holds one coefficient while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (coeffs.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			coef_q <= head;
			idx_q  <= IDX_W'(emit_idx);
			last_q <= ctl.emit_last;
		end
	end

	assign coeffs.valid       = out_valid_q;
	assign coeffs.coefficient = coef_q;
	assign coeffs.coeff_index = idx_q;
	assign coeffs.last        = last_q;

endmodule

FILE: tb/fwht_coef_checker.sv
`timescale 1ns / 1ps

// Watches the three channels, keeps its own copy of the frame store and log_size,
// and compares every coefficient with the oldest one predicted.
module fwht_coef_checker #(
	parameter int LOG_POINTS = fwht_pkg::LOG_POINTS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	fwht_sample_if samples,
	fwht_coef_if   coeffs,
	fwht_cfg_if    cfg,
	output int     fail_count,
	output int     coef_pending
);
	import fwht_pkg::*;

	localparam int POINTS = 1 << LOG_POINTS;

	typedef struct {
		coef_t            coefficient;
		logic [IDX_W-1:0] coeff_index;
		logic             last;
	} walsh_coef_t;

	logsize_t    log_cfg;
	coef_t       frame_buf [POINTS];
	int          frame_fill;
	int          mismatches;
	walsh_coef_t coef_due [$];

	// Store one sample; the frame's last one triggers the transform and queues
	// every coefficient. Sums wrap at COEF_W bits like the hardware.
	function automatic void absorb_sample(input sample_t v);
		int          k;
		int          n;
		coef_t       x;
		coef_t       y;
		walsh_coef_t c;
		k = (log_cfg == 0) ? 1 : int'(log_cfg);
		if (k > LOG_POINTS)
			k = LOG_POINTS;
		n = 1 << k;
		if (frame_fill >= n)
			frame_fill = 0;
		frame_buf[frame_fill % POINTS] = coef_t'(v);
		frame_fill++;
		if (frame_fill < n)
			return;
		frame_fill = 0;
		for (int half = 1; half < n; half *= 2)
			for (int base = 0; base < n; base += 2 * half)
				for (int j = base; j < base + half; j++) begin
					x = frame_buf[j];
					y = frame_buf[j + half];
					frame_buf[j]        = x + y;
					frame_buf[j + half] = x - y;
				end
		for (int s = 0; s < n; s++) begin
			c.coefficient = frame_buf[s];
			c.coeff_index = s[IDX_W-1:0];
			c.last        = (s == n - 1);
			coef_due.push_back(c);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		walsh_coef_t want;
		if (!arst_n) begin
			log_cfg    = logsize_t'(LOG_POINTS_DEF);
			frame_fill = 0;
			mismatches = 0;
			coef_due.delete();
			fail_count   <= 0;
			coef_pending <= 0;
		end else begin
			// output first: a coefficient never belongs to a frame closing this edge
			if (coeffs.valid && coeffs.ready) begin
				if (coef_due.size() == 0) begin
					$error("unexpected item: coefficient %0d coeff_index %0d last %0b",
						coeffs.coefficient, coeffs.coeff_index, coeffs.last);
					mismatches++;
				end else begin
					want = coef_due.pop_front();
					if (coeffs.coefficient !== want.coefficient) begin
						$error("coefficient: expected %0d, actual %0d",
							want.coefficient, coeffs.coefficient);
						mismatches++;
					end
					if (coeffs.coeff_index !== want.coeff_index) begin
						$error("coeff_index: expected %0d, actual %0d",
							want.coeff_index, coeffs.coeff_index);
						mismatches++;
					end
					if (coeffs.last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, coeffs.last);
						mismatches++;
					end
				end
			end
			// any write drops the partial frame
			if (cfg.valid && cfg.ready) begin
				log_cfg    = cfg.log_size;
				frame_fill = 0;
			end
			if (samples.valid && samples.ready)
				absorb_sample(samples.sample);
			fail_count   <= mismatches;
			coef_pending <= coef_due.size();
		end
	end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

// Top of the transform bench: clock, reset, sample and log_size stimulus, the
// coefficient receiver with its random stalls, a no-progress watchdog and the verdict.
// All checking lives in fwht_coef_checker.
module tb;
	import fwht_pkg::*;

	localparam int RAND_ITEMS  = 280;   // samples to send through send_frame
	localparam int STALL_LIMIT = 4000;  // cycles without any handshake before giving up
	localparam int SQUEEZE_LEN = 700;   // one long receiver hold-off
	localparam int SETTLE      = 8;     // quiet cycles before touching log_size
	localparam int IDLE_PCT    = 26;

	localparam sample_t SAMPLE_MAX = 16'sh7FFF;
	localparam sample_t SAMPLE_MIN = 16'sh8000;

	// how a frame's samples are drawn
	typedef enum int {
		FILL_RANDOM,
		FILL_EXTREME,
		FILL_SMALL,
		FILL_MAX,
		FILL_MIN
	} fill_mode_t;

	logic clk;
	logic arst_n;
	bit   steady;       // both sides stop idling while set
	bit   squeeze_req;  // asks the receiver for its one long hold-off
	int   sent;         // random samples accepted so far
	int   fail_count;
	int   coef_pending;

	fwht_sample_if samples();
	fwht_coef_if   coeffs();
	fwht_cfg_if    cfg();

	fast_walsh_hadamard_transform_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples),
		.coeffs (coeffs),
		.cfg    (cfg)
	);

	fwht_coef_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples),
		.coeffs      (coeffs),
		.cfg         (cfg),
		.fail_count  (fail_count),
		.coef_pending(coef_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic sample_t pick_sample(input fill_mode_t mode);
		case (mode)
			FILL_RANDOM:  return sample_t'($urandom);
			FILL_EXTREME: return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
			FILL_SMALL:   return sample_t'(int'($urandom_range(16)) - 8);
			FILL_MAX:     return SAMPLE_MAX;
			default:      return SAMPLE_MIN;
		endcase
	endfunction

	// One sample item. valid stays high on return so back-to-back items need no
	// extra NBA; an idle gap drops it first.
	task automatic send_sample(input sample_t v);
		int gap;
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			samples.valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		samples.valid  <= 1'b1;
		samples.sample <= v;
		@(posedge clk);
		while (!samples.ready) @(posedge clk);
	endtask

	// a count short of the frame length leaves a partial frame behind
	task automatic send_frame(input fill_mode_t mode, input int count);
		for (int i = 0; i < count; i++) begin
			send_sample(pick_sample(mode));
			sent++;
		end
	endtask

	task automatic write_log_size(input logsize_t v);
		cfg.valid    <= 1'b1;
		cfg.log_size <= v;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Called in the step of the last sample handshake. The pending count is an NBA
	// output of the checker, so read it only after the following clock edge.
	task automatic wait_drained();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (coef_pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Coefficient receiver: random stalls, a steady stretch, and one long hold-off
	// counted here so the core fills up and refuses samples.
	initial begin
		int hold;
		bit squeezed;
		hold     = 0;
		squeezed = 1'b0;
		coeffs.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				coeffs.ready <= 1'b0;
			end else if (squeeze_req && !squeezed) begin
				squeezed = 1'b1;
				hold     = SQUEEZE_LEN - 1;
				coeffs.ready <= 1'b0;
			end else if (steady) begin
				coeffs.ready <= 1'b1;
			end else begin
				coeffs.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: any handshake on any channel counts as progress.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((samples.valid && samples.ready) || (coeffs.valid && coeffs.ready) ||
				(cfg.valid && cfg.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[fast_walsh_hadamard_transform_core] ERROR");
		$finish;
	end

	initial begin
		sample_t pattern [$];
		int      k;
		int      n;
		int      frames;
		int      pick;

		samples.valid  <= 1'b0;
		samples.sample <= '0;
		cfg.valid      <= 1'b0;
		cfg.log_size   <= '0;
		arst_n         <= 1'b0;
		steady         <= 1'b0;
		squeeze_req    <= 1'b0;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// three samples at the reset size (64 points), then a write: the partial
		// frame must be dropped, otherwise the size-4 frame below closes early
		for (int i = 0; i < 3; i++)
			send_sample(pick_sample(FILL_RANDOM));
		wait_drained();
		write_log_size(logsize_t'(2));
		for (int i = 0; i < 4; i++)
			send_sample(SAMPLE_MIN);
		wait_drained();

		// two-point frames, every pairing of the extremes
		write_log_size(logsize_t'(1));
		pattern = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN,
			SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX};
		foreach (pattern[i])
			send_sample(pattern[i]);
		wait_drained();

		// log_size 0 behaves as 1; alternating bit patterns
		write_log_size(logsize_t'(0));
		send_sample(16'sh5555);
		send_sample(16'shAAAA);
		wait_drained();

		write_log_size(logsize_t'(2));
		pattern = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN};
		foreach (pattern[i])
			send_sample(pattern[i]);
		wait_drained();

		// --- random ---
		// full-scale negative 64-point frame: the most negative coefficient
		write_log_size(logsize_t'(6));
		send_frame(FILL_MIN, 64);
		wait_drained();

		// log_size 7 clamps to 64 points; the receiver holds off meanwhile and the
		// next frame's items are offered against a full core, then left partial
		write_log_size(logsize_t'(7));
		squeeze_req <= 1'b1;
		send_frame(FILL_RANDOM, 64);
		send_frame(FILL_EXTREME, 10);

		// mostly small sizes; sometimes a trailing partial frame that the next
		// write throws away
		while (sent < RAND_ITEMS) begin
			wait_drained();
			steady <= (sent >= 170 && sent < 240);
			pick = $urandom_range(99);
			k = (pick < 8)  ? 0 : (pick < 24) ? 1 : (pick < 44) ? 2 : (pick < 64) ? 3 :
				(pick < 80) ? 4 : (pick < 92) ? 5 : (pick < 96) ? 6 : 7;
			write_log_size(logsize_t'(k));
			n = 1 << ((k == 0) ? 1 : (k > LOG_POINTS_DEF) ? LOG_POINTS_DEF : k);
			frames = (n >= 32) ? 1 : $urandom_range(1, 4);
			repeat (frames)
				send_frame(fill_mode_t'($urandom_range(0, 4)), n);
			if ($urandom_range(3) == 0)
				send_frame(fill_mode_t'($urandom_range(0, 4)), $urandom_range(1, n - 1));
		end

		wait_drained();
		repeat (4 * SETTLE) @(posedge clk);
		if (fail_count == 0 && coef_pending == 0)
			$display("[fast_walsh_hadamard_transform_core] OK");
		else
			$display("[fast_walsh_hadamard_transform_core] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
design/fwht_pkg.sv
design/fwht_if.sv
design/fwht_cell.sv
design/fwht_ctrl.sv
design/fast_walsh_hadamard_transform_core.sv
tb/fwht_coef_checker.sv
tb/tb.sv
